// ===== sv/kufef_pkg.sv =====
package kufef_pkg;

  localparam int VERT_W = 10;
  localparam int RANK_W = 4;

  typedef logic [VERT_W-1:0] vert_t;
  typedef logic [RANK_W-1:0] rank_t;

  // rank saturates here
  localparam rank_t RANK_MAX = 4'd15;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

  typedef struct packed {
    logic  valid;
    logic  accepted;
    logic  tree_complete;
    vert_t count;
  } res_t;

endpackage

// ===== sv/kufef_forest_mem.sv =====
module kufef_forest_mem #(
  parameter int MAX_VERTICES = 1024,
  parameter int IW           = 10
) (
  input  logic                 clk,
  input  kufef_pkg::mem_cmd_t  cmd,
  input  logic [IW-1:0]        rd_addr,
  input  logic [IW-1:0]        wr_addr,
  input  logic [IW-1:0]        wr_parent,
  input  kufef_pkg::rank_t     wr_rank,
  output logic [IW-1:0]        rd_parent,
  output kufef_pkg::rank_t     rd_rank
);
  import kufef_pkg::*;

  // parent and rank share one address, written and read together
  logic [IW-1:0] parent_mem [MAX_VERTICES];
  rank_t         rank_mem   [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      parent_mem[wr_addr] <= wr_parent;
      rank_mem[wr_addr]   <= wr_rank;
    end
    if (cmd.rd) begin
      rd_parent <= parent_mem[rd_addr];
      rd_rank   <= rank_mem[rd_addr];
    end
  end

endmodule

// ===== sv/kufef_ctrl.sv =====
module kufef_ctrl #(
  parameter int MAX_VERTICES = 1024,
  parameter int IW           = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_take,
  input  kufef_pkg::vert_t    vertex_a,
  input  kufef_pkg::vert_t    vertex_b,
  input  kufef_pkg::vert_t    vc_eff,
  input  logic                res_ready,
  output logic                idle,
  output kufef_pkg::res_t     res
);
  import kufef_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_FA    = 4'd3;
  localparam logic [3:0] S_CA    = 4'd4;
  localparam logic [3:0] S_FB    = 4'd5;
  localparam logic [3:0] S_CB    = 4'd6;
  localparam logic [3:0] S_UNION = 4'd7;
  localparam logic [3:0] S_RANK  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [IW-1:0] LAST = IW'(MAX_VERTICES - 1);

  logic [3:0]    state, state_next;
  logic [IW-1:0] cur, cur_next;
  vert_t         a_in, b_in;
  logic [IW-1:0] root_a, root_b;
  rank_t         rank_a, rank_b;
  logic          acc, full;
  vert_t         edge_count;

  mem_cmd_t      cmd;
  logic [IW-1:0] rd_addr, wr_addr, wr_parent, rd_parent;
  rank_t         wr_rank, rd_rank;

  logic [IW-1:0] a_idx, b_idx;
  logic          full_now, in_range;

  assign a_idx    = IW'(a_in);
  assign b_idx    = IW'(b_in);
  assign full_now = edge_count >= (vc_eff - 10'd1);
  assign in_range = (a_in != '0) && (a_in <= vc_eff) && (b_in != '0) && (b_in <= vc_eff);

  kufef_forest_mem #(
    .MAX_VERTICES(MAX_VERTICES),
    .IW          (IW)
  ) u_mem (
    .clk      (clk),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_parent(wr_parent),
    .wr_rank  (wr_rank),
    .rd_parent(rd_parent),
    .rd_rank  (rd_rank)
  );

  always_comb begin
    state_next = state;
    cur_next   = cur;
    cmd        = '0;
    rd_addr    = cur;
    wr_addr    = cur;
    wr_parent  = cur;
    wr_rank    = '0;
    case (state)
      S_CLEAR: begin
        cmd.wr = 1'b1;
        if (cur == LAST) begin
          state_next = S_IDLE;
        end else begin
          cur_next = cur + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (full_now || !in_range) begin
          state_next = S_DONE;
        end else begin
          cmd.rd     = 1'b1;
          rd_addr    = a_idx;
          cur_next   = a_idx;
          state_next = S_FA;
        end
      end
      S_FA: begin
        cmd.rd = 1'b1;
        if (rd_parent == cur) begin
          rd_addr    = a_idx;
          cur_next   = a_idx;
          state_next = S_CA;
        end else begin
          rd_addr  = rd_parent;
          cur_next = rd_parent;
        end
      end
      S_CA: begin
        cmd.rd = 1'b1;
        if (cur == root_a) begin
          rd_addr    = b_idx;
          cur_next   = b_idx;
          state_next = S_FB;
        end else begin
          cmd.wr    = 1'b1;
          wr_parent = root_a;
          wr_rank   = rd_rank;
          rd_addr   = rd_parent;
          cur_next  = rd_parent;
        end
      end
      S_FB: begin
        cmd.rd = 1'b1;
        if (rd_parent == cur) begin
          rd_addr    = b_idx;
          cur_next   = b_idx;
          state_next = S_CB;
        end else begin
          rd_addr  = rd_parent;
          cur_next = rd_parent;
        end
      end
      S_CB: begin
        if (cur == root_b) begin
          state_next = S_UNION;
        end else begin
          cmd.rd    = 1'b1;
          cmd.wr    = 1'b1;
          wr_parent = root_b;
          wr_rank   = rd_rank;
          rd_addr   = rd_parent;
          cur_next  = rd_parent;
        end
      end
      S_UNION: begin
        state_next = S_DONE;
        if (root_a != root_b) begin
          cmd.wr = 1'b1;
          if (rank_a < rank_b) begin
            wr_addr   = root_a;
            wr_parent = root_b;
            wr_rank   = rank_a;
          end else begin
            wr_addr   = root_b;
            wr_parent = root_a;
            wr_rank   = rank_b;
            if ((rank_a == rank_b) && (rank_a != RANK_MAX)) begin
              state_next = S_RANK;
            end
          end
        end
      end
      S_RANK: begin
        cmd.wr     = 1'b1;
        wr_addr    = root_a;
        wr_parent  = root_a;
        wr_rank    = rank_a + 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cur        <= '0;
      edge_count <= '0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      if ((state == S_UNION) && (root_a != root_b)) begin
        edge_count <= edge_count + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_in <= vertex_a;
      b_in <= vertex_b;
    end
    if (state == S_CHECK) begin
      acc  <= 1'b0;
      full <= full_now;
    end
    if ((state == S_FA) && (rd_parent == cur)) begin
      root_a <= cur;
      rank_a <= rd_rank;
    end
    if ((state == S_FB) && (rd_parent == cur)) begin
      root_b <= cur;
      rank_b <= rd_rank;
    end
    if ((state == S_UNION) && (root_a != root_b)) begin
      acc <= 1'b1;
    end
  end

  assign idle              = (state == S_IDLE);
  assign res.valid         = (state == S_DONE);
  assign res.accepted      = acc;
  assign res.tree_complete = full;
  assign res.count         = edge_count;

endmodule

// ===== sv/kruskal_union_find_edge_filter_top.sv =====
// steps: check the edge, walk and then compress the parent chain of vertex a, then of
// vertex b, then union the two roots, plus a rank write when a rank tie raises a rank;
// an out-of-range edge or one ignored on a full tree goes from the check straight to the result
// throughput: one edge at a time, the next taken once its result is registered
// reset: synchronous; a clearing pass then sets every parent entry to its own index and
// every rank to zero, with no input transaction taken until it ends
module kruskal_union_find_edge_filter_top #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic       clk,
  input  logic       rst,
  // input edge channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [9:0] vertex_a,
  input  logic [9:0] vertex_b,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       accepted,
  output logic       tree_complete,
  output logic [9:0] accepted_count,
  // vertex count register write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [9:0] cfg_data
);
  import kufef_pkg::*;

  localparam int IW   = $clog2(MAX_VERTICES);
  // largest usable vertex number, limited by both the table depth and the 10-bit fields
  localparam int VLIM = (MAX_VERTICES - 1 < 1023) ? MAX_VERTICES - 1 : 1023;

  vert_t vertex_count;
  vert_t vc_eff;
  logic  idle;
  logic  in_take;
  logic  res_ready;
  res_t  res;

  // the register is always ready to be written
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= 10'd1023;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  // zero counts as one vertex, too large a count is clamped to the table
  always_comb begin
    vc_eff = (vertex_count == '0) ? 10'd1 : vertex_count;
    if (vc_eff > 10'(VLIM)) begin
      vc_eff = 10'(VLIM);
    end
  end

  // stall whenever the sequencer is busy with an edge or the clearing pass
  assign in_stall = !idle;
  assign in_take  = in_valid && idle;

  // the output register frees up when empty or being taken this cycle
  assign res_ready = !out_valid || !out_stall;

  kufef_ctrl #(
    .MAX_VERTICES(MAX_VERTICES),
    .IW          (IW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_take  (in_take),
    .vertex_a (vertex_a),
    .vertex_b (vertex_b),
    .vc_eff   (vc_eff),
    .res_ready(res_ready),
    .idle     (idle),
    .res      (res)
  );

  // output register: holds a finished result while the next edge is being taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      accepted       <= res.accepted;
      tree_complete  <= res.tree_complete;
      accepted_count <= res.count;
    end
  end

endmodule
